@@ rtl/xml_highlight_lexer_assert.svh @@
// Assertion macros for the XML highlight lexer.
`ifndef XML_HIGHLIGHT_LEXER_ASSERT_SVH
`define XML_HIGHLIGHT_LEXER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define XHL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define XHL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/xhl_pkg.sv @@
// Package: types, state codes and color tables of the XML highlight lexer.
package xhl_pkg;

  localparam int POS_BITS = 32;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [4:0] {
    ST_ERROR = 5'd0,
    ST_TEXT  = 5'd1,
    ST_LT    = 5'd2,
    ST_AMP   = 5'd3,
    ST_TAG   = 5'd4,
    ST_ATT   = 5'd5,
    ST_AV1   = 5'd6,
    ST_AV2   = 5'd7,
    ST_LB    = 5'd8,
    ST_LBD   = 5'd9,
    ST_COM   = 5'd10,
    ST_COMD  = 5'd11,
    ST_COMDD = 5'd12,
    ST_K0    = 5'd13,
    ST_K1    = 5'd14,
    ST_K2    = 5'd15,
    ST_K3    = 5'd16,
    ST_K4    = 5'd17,
    ST_K5    = 5'd18,
    ST_CD    = 5'd19,
    ST_CDR   = 5'd20,
    ST_CDRR  = 5'd21
  } lex_state_t;

  typedef struct packed {
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [23:0] color;
  } span_t;

  // Spans produced by one accepted word, first span in sp_a.
  typedef struct packed {
    logic [1:0] count;
    span_t      sp_a;
    span_t      sp_b;
  } lex_result_t;

  // Style colors as 0xBBGGRR.
  localparam logic [23:0] RGB_RED    = 24'h0000FF;
  localparam logic [23:0] RGB_BLUE   = 24'hFF0000;
  localparam logic [23:0] RGB_MAROON = 24'h000080;
  localparam logic [23:0] RGB_GREEN  = 24'h008000;
  localparam logic [23:0] RGB_NAVY   = 24'h800000;
  localparam logic [23:0] RGB_BLACK  = 24'h000000;
  localparam logic [23:0] RGB_PURPLE = 24'h800080;

  // Map a state to the color of its style.
  function automatic logic [23:0] color_of(logic [4:0] st);
    logic [23:0] c;
    case (st)
      ST_TEXT:                        c = RGB_BLACK;
      ST_LT, ST_AMP, ST_K5, ST_CDRR:  c = RGB_BLUE;
      ST_TAG, ST_LB, ST_LBD:          c = RGB_NAVY;
      ST_ATT:                         c = RGB_PURPLE;
      ST_AV1, ST_AV2:                 c = RGB_MAROON;
      ST_COM, ST_COMD, ST_COMDD:      c = RGB_GREEN;
      ST_K0, ST_K1, ST_K2, ST_K3,
      ST_K4, ST_CD, ST_CDR:           c = RGB_MAROON;
      default:                        c = RGB_RED;
    endcase
    return c;
  endfunction

  // Letter expected in each state of the CDATA keyword prefix.
  function automatic logic [15:0] cdata_char(logic [4:0] st);
    logic [15:0] c;
    case (st)
      ST_K0:   c = 16'h0043;
      ST_K1:   c = 16'h0044;
      ST_K2:   c = 16'h0041;
      ST_K3:   c = 16'h0054;
      ST_K4:   c = 16'h0041;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  // Low 32 bits of a position, zero extended when positions are narrower.
  function automatic logic [31:0] pos_out(pos_t p);
    logic [63:0] w;
    w = 64'(p);
    return w[31:0];
  endfunction

endpackage

@@ rtl/xhl_char_if.sv @@
// Interfaces: character channel and span channel.
interface xhl_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] ch;
  logic        end_of_text;

  modport source (output valid, ch, end_of_text, input ready);
  modport sink (input valid, ch, end_of_text, output ready);
endinterface

interface xhl_span_if;
  logic        valid;
  logic        ready;
  logic [31:0] span_start;
  logic [31:0] span_end;
  logic [23:0] span_color;
  logic        span_last;

  modport source (output valid, span_start, span_end, span_color, span_last, input ready);
  modport sink (input valid, span_start, span_end, span_color, span_last, output ready);
endinterface

@@ rtl/xhl_lexer.sv @@
// Lexer core: state registers and the per-word span logic.
module xhl_lexer
  import xhl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [15:0] ch,
  input  logic        end_of_text,
  output lex_result_t result
);

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CONT,
    ACT_END,
    ACT_START,
    ACT_CDSTART,
    ACT_CDEND,
    ACT_FLUSH
  } act_t;

  localparam logic [15:0] CH_LT    = 16'h003C;
  localparam logic [15:0] CH_AMP   = 16'h0026;
  localparam logic [15:0] CH_SEMI  = 16'h003B;
  localparam logic [15:0] CH_BANG  = 16'h0021;
  localparam logic [15:0] CH_DASH  = 16'h002D;
  localparam logic [15:0] CH_GT    = 16'h003E;
  localparam logic [15:0] CH_LBRK  = 16'h005B;
  localparam logic [15:0] CH_RBRK  = 16'h005D;
  localparam logic [15:0] CH_DQ    = 16'h0022;
  localparam logic [15:0] CH_SQ    = 16'h0027;
  localparam logic [15:0] CH_SP    = 16'h0020;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_CR    = 16'h000D;

  logic [4:0] lex_state, lex_state_next;
  pos_t       char_position, char_position_next;
  pos_t       token_start, token_start_next;

  act_t       act;
  logic [4:0] nx;
  pos_t       extra;
  logic       is_space;
  logic       close1, emit1, emit2;
  pos_t       e1, s1;
  logic [23:0] c1;
  span_t      span1, span2;

  assign is_space = (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);

  // Decode the action for this word.
  always_comb begin
    act   = ACT_NONE;
    nx    = lex_state;
    extra = '0;
    if (end_of_text) begin
      act = ACT_FLUSH;
      nx  = ST_TEXT;
    end else begin
      case (lex_state)
        ST_K0, ST_K1, ST_K2, ST_K3, ST_K4: begin
          act = ACT_CONT;
          nx  = (ch == cdata_char(lex_state)) ? lex_state + 5'd1 : ST_TAG;
        end
        ST_K5: begin
          if (ch == CH_LBRK) begin
            act   = ACT_CDSTART;
            nx    = ST_CD;
            extra = pos_t'(1);
          end else begin
            act = ACT_CONT;
            nx  = ST_TAG;
          end
        end
        ST_TEXT: begin
          if (ch == CH_LT) begin
            act = ACT_START;
            nx  = ST_LT;
          end else if (ch == CH_AMP) begin
            act = ACT_START;
            nx  = ST_AMP;
          end
        end
        ST_AMP: begin
          if (ch == CH_SEMI) begin
            act   = ACT_END;
            nx    = ST_TEXT;
            extra = pos_t'(1);
          end else begin
            act = ACT_CONT;
          end
        end
        ST_LT: begin
          act = ACT_CONT;
          nx  = (ch == CH_BANG) ? ST_LB : ST_TAG;
        end
        ST_LB: begin
          act = ACT_CONT;
          if (ch == CH_DASH) begin
            nx = ST_LBD;
          end else if (ch == CH_GT) begin
            act = ACT_END;
            nx  = ST_TEXT;
          end else if (ch == CH_LBRK) begin
            nx = ST_K0;
          end else begin
            nx = ST_TAG;
          end
        end
        ST_LBD: begin
          if (ch == CH_DASH) begin
            act = ACT_START;
            nx  = ST_COM;
          end else begin
            act = ACT_CONT;
            nx  = ST_TAG;
          end
        end
        ST_CD: begin
          act = ACT_CONT;
          nx  = (ch == CH_RBRK) ? ST_CDR : ST_CD;
        end
        ST_CDR: begin
          act = ACT_CONT;
          nx  = (ch == CH_RBRK) ? ST_CDRR : ST_CD;
        end
        ST_CDRR: begin
          if (ch == CH_GT) begin
            act   = ACT_CDEND;
            nx    = ST_TEXT;
            extra = '0 - pos_t'(3);
          end else begin
            act = ACT_CONT;
            nx  = ST_CD;
          end
        end
        ST_COM: begin
          act = ACT_CONT;
          nx  = (ch == CH_DASH) ? ST_COMD : ST_COM;
        end
        ST_COMD: begin
          act = ACT_CONT;
          nx  = (ch == CH_DASH) ? ST_COMDD : ST_COM;
        end
        ST_COMDD: begin
          if (ch == CH_GT) begin
            act   = ACT_END;
            nx    = ST_TEXT;
            extra = '0 - pos_t'(3);
          end else begin
            act = ACT_CONT;
            nx  = ST_COM;
          end
        end
        ST_TAG: begin
          if (ch == CH_GT) begin
            act = ACT_END;
            nx  = ST_TEXT;
          end else if (is_space) begin
            act = ACT_END;
            nx  = ST_ATT;
          end else begin
            act = ACT_CONT;
          end
        end
        ST_ATT: begin
          if (ch == CH_DQ) begin
            act = ACT_START;
            nx  = ST_AV2;
          end else if (ch == CH_SQ) begin
            act = ACT_START;
            nx  = ST_AV1;
          end else if (ch == CH_GT) begin
            act = ACT_END;
            nx  = ST_TEXT;
          end
        end
        ST_AV1: begin
          if (ch == CH_SQ) begin
            act   = ACT_END;
            nx    = ST_ATT;
            extra = pos_t'(1);
          end else begin
            act = ACT_CONT;
          end
        end
        ST_AV2: begin
          if (ch == CH_DQ) begin
            act   = ACT_END;
            nx    = ST_ATT;
            extra = pos_t'(1);
          end else begin
            act = ACT_CONT;
          end
        end
        default: begin
          act = ACT_NONE;
        end
      endcase
    end
  end

  // Close the pending token, then open a marker or second closing span.
  always_comb begin
    close1 = (act == ACT_END) || (act == ACT_START) || (act == ACT_CDSTART) ||
             (act == ACT_CDEND) || (act == ACT_FLUSH) ||
             ((act == ACT_CONT) && (nx != lex_state));
    e1     = char_position + extra;
    s1     = (act == ACT_CDSTART) ? char_position - pos_t'(8) : token_start;
    c1     = (act == ACT_CDEND) ? color_of(ST_CD) : color_of(lex_state);
    emit1  = close1 && (s1 != e1);
    emit2  = (act == ACT_START) || (act == ACT_CDSTART) || (act == ACT_CDEND);

    span1.start_pos = pos_out(s1);
    span1.end_pos   = pos_out(e1);
    span1.color     = c1;

    span2.start_pos = pos_out(e1);
    if (act == ACT_CDEND) begin
      span2.end_pos = pos_out(char_position + pos_t'(4));
      span2.color   = color_of(ST_CDRR);
    end else begin
      span2.end_pos = pos_out(e1 + pos_t'(1));
      span2.color   = color_of(nx);
    end

    result.count = {1'b0, emit1} + {1'b0, emit2};
    result.sp_a  = emit1 ? span1 : span2;
    result.sp_b  = span2;

    lex_state_next = nx;
    if (act == ACT_FLUSH) begin
      token_start_next   = '0;
      char_position_next = '0;
    end else begin
      char_position_next = char_position + pos_t'(1);
      if (act == ACT_CDEND) begin
        token_start_next = char_position + pos_t'(4);
      end else if (close1) begin
        token_start_next = e1;
      end else begin
        token_start_next = token_start;
      end
    end
  end

  // Advance the lexer state on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state     <= ST_TEXT;
      char_position <= '0;
      token_start   <= '0;
    end else if (accept) begin
      lex_state     <= lex_state_next;
      char_position <= char_position_next;
      token_start   <= token_start_next;
    end
  end

endmodule

@@ rtl/xhl_span_buf.sv @@
// Span buffer: two-entry result register that feeds the span channel.
module xhl_span_buf
  import xhl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  lex_result_t result,
  output logic        room,
  xhl_span_if.source  spans
);

  logic [1:0] count;
  span_t      head, tail;
  logic       head_last;
  logic       pop;

  assign pop  = spans.valid && spans.ready;
  // Take a new word only when the buffer is empty or its last entry drains this cycle.
  assign room = (count == 2'd0) || ((count == 2'd1) && spans.ready);

  // Hold count; load both entries on push, shift on pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push) begin
      count <= result.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      head      <= result.sp_a;
      tail      <= result.sp_b;
      head_last <= (result.count == 2'd1);
    end else if (pop) begin
      head      <= tail;
      head_last <= 1'b1;
    end
  end

  assign spans.valid      = (count != 2'd0);
  assign spans.span_start = head.start_pos;
  assign spans.span_end   = head.end_pos;
  assign spans.span_color = head.color;
  assign spans.span_last  = head_last;

endmodule

@@ rtl/xml_highlight_lexer.sv @@
// Top level of the XML highlight lexer.
//
//   channel  dir  handshake     payload
//   chars    in   valid/ready   ch[15:0], end_of_text
//   spans    out  valid/ready   span_start[31:0], span_end[31:0], span_color[23:0], span_last
//
// One character word per cycle while the span buffer has room; its first span appears in the cycle after acceptance.
// A word that yields two spans holds chars.ready low while both spans sit in
// the two-entry span buffer.
// Synchronous reset returns the lexer to the text state at position zero.
// A stall on spans backs up into chars.ready in the same cycle.
`include "xml_highlight_lexer_assert.svh"

module xml_highlight_lexer
  import xhl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  xhl_char_if.sink   chars,
  xhl_span_if.source spans
);

  logic        accept;
  logic        room;
  lex_result_t result;

  assign chars.ready = room;
  assign accept      = chars.valid && room;

  xhl_lexer u_lexer (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .ch          (chars.ch),
    .end_of_text (chars.end_of_text),
    .result      (result)
  );

  xhl_span_buf u_span_buf (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .result (result),
    .room   (room),
    .spans  (spans)
  );

  // Checks
  `XHL_ASSERT_NXT(a_two_spans, accept && (result.count == 2'd2), spans.valid && !spans.span_last, "two-span word did not present a non-last head")
  `XHL_ASSERT_NXT(a_second_follows, spans.valid && spans.ready && !spans.span_last, spans.valid, "second span did not follow")
  `XHL_ASSERT_IMP(a_ready_drains, chars.ready, !spans.valid || spans.ready, "input ready while span buffer cannot drain")

endmodule
